@@ src/ggh_pkg.sv @@
// ggh_pkg: shared types, constants and tables for the gamepad host sequencer
// no dependencies
package ggh_pkg;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_OUT_DONE = 2'd1,
		CMD_BYTE = 2'd2,
		CMD_IN_FAIL = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_STALL = 2'd1;

	localparam logic [1:0] REG_GIP_MODE = 2'd0;
	localparam logic [1:0] REG_VENDOR_ID = 2'd1;
	localparam logic [1:0] REG_PRODUCT_ID = 2'd2;

	// slots past the defined entries never match
	localparam int DEFINED_SLOTS = 19;

	localparam logic [7:0] H0_ANNOUNCE = 8'h02;
	localparam logic [7:0] H0_STATUS = 8'h03;
	localparam logic [7:0] H0_GUIDE = 8'h07;
	localparam logic [7:0] H0_INPUT = 8'h20;
	localparam logic [7:0] MIN_LEGACY_LEN = 8'd14;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic final_byte;
		logic [1:0] xfer_status;
		logic [1:0] player_number;
	} in_word_t;

	typedef struct packed {
		logic kind;
		logic [7:0] packet_byte;
		logic packet_end;
		logic deliver_report;
		logic home_valid;
		logic home_pressed;
		logic rearm_in;
	} out_word_t;

	// packet source selected by the front part
	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_WALK = 2'd1,
		SRC_LED = 2'd2,
		SRC_ACK = 2'd3
	} src_t;

	// classified event handed to the back part
	typedef struct packed {
		src_t src;
		logic restart;
		logic [1:0] player_number;
		logic [7:0] ack_seq;
		logic deliver_report;
		logic home_valid;
		logic home_pressed;
		logic rearm_in;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_WALK = 2'd1,
		BK_EMIT = 2'd2,
		BK_VERDICT = 2'd3
	} bk_state_t;

	typedef struct packed {
		logic [15:0] vid;
		logic [15:0] pid;
		logic [2:0] pkt;
	} init_entry_t;

	function automatic init_entry_t init_entry(input logic [4:0] i);
		init_entry_t e;
		e = '{vid: 16'h0000, pid: 16'h0000, pkt: 3'd0};
		case (i)
			5'd0: e = '{16'h0e6f, 16'h0165, 3'd2};
			5'd1: e = '{16'h0f0d, 16'h0067, 3'd2};
			5'd2: e = '{16'h1430, 16'h079b, 3'd2};
			5'd3: e = '{16'h0000, 16'h0000, 3'd0};
			5'd4: e = '{16'h045e, 16'h02ea, 3'd1};
			5'd5: e = '{16'h045e, 16'h0b00, 3'd1};
			5'd6: e = '{16'h045e, 16'h0b00, 3'd5};
			5'd7: e = '{16'h0e6f, 16'h0000, 3'd3};
			5'd8: e = '{16'h1430, 16'h079b, 3'd3};
			5'd9: e = '{16'h20d6, 16'ha01a, 3'd3};
			5'd10: e = '{16'h0e6f, 16'h0000, 3'd4};
			5'd11: e = '{16'h1430, 16'h079b, 3'd4};
			5'd12: e = '{16'h20d6, 16'ha01a, 3'd4};
			5'd13: e = '{16'h24c6, 16'h541a, 3'd6};
			5'd14: e = '{16'h24c6, 16'h542a, 3'd6};
			5'd15: e = '{16'h24c6, 16'h543a, 3'd6};
			5'd16: e = '{16'h24c6, 16'h541a, 3'd7};
			5'd17: e = '{16'h24c6, 16'h542a, 3'd7};
			5'd18: e = '{16'h24c6, 16'h543a, 3'd7};
			default: e = '{16'h0000, 16'h0000, 3'd0};
		endcase
		return e;
	endfunction

	function automatic logic [3:0] pkt_len(input logic [2:0] p);
		logic [3:0] l;
		case (p)
			3'd0: l = 4'd5;
			3'd1: l = 4'd5;
			3'd2: l = 4'd13;
			3'd3: l = 4'd7;
			3'd4: l = 4'd6;
			3'd5: l = 4'd6;
			default: l = 4'd13;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] pkt_body(input logic [2:0] p, input logic [3:0] k);
		logic [7:0] b;
		b = 8'h00;
		case (p)
			3'd0: case (k)
				4'd0: b = 8'h05; 4'd1: b = 8'h20; 4'd3: b = 8'h01;
				default: b = 8'h00;
			endcase
			3'd1: case (k)
				4'd0: b = 8'h05; 4'd1: b = 8'h20; 4'd3: b = 8'h0f; 4'd4: b = 8'h06;
				default: b = 8'h00;
			endcase
			3'd2: case (k)
				4'd0: b = 8'h01; 4'd1: b = 8'h20; 4'd3: b = 8'h09; 4'd5: b = 8'h04;
				4'd6: b = 8'h20; 4'd7: b = 8'h3a; 4'd11: b = 8'h80;
				default: b = 8'h00;
			endcase
			3'd3: case (k)
				4'd0: b = 8'h0a; 4'd1: b = 8'h20; 4'd3: b = 8'h03; 4'd5: b = 8'h01;
				4'd6: b = 8'h14;
				default: b = 8'h00;
			endcase
			3'd4: case (k)
				4'd0: b = 8'h06; 4'd1: b = 8'h20; 4'd3: b = 8'h02; 4'd4: b = 8'h01;
				default: b = 8'h00;
			endcase
			3'd5: case (k)
				4'd0: b = 8'h4d; 4'd1: b = 8'h10; 4'd2: b = 8'h01; 4'd3: b = 8'h02;
				4'd4: b = 8'h07;
				default: b = 8'h00;
			endcase
			3'd6: case (k)
				4'd0: b = 8'h09; 4'd3: b = 8'h09; 4'd5: b = 8'h0f; 4'd8: b = 8'h1d;
				4'd9: b = 8'h1d; 4'd10: b = 8'hff;
				default: b = 8'h00;
			endcase
			default: case (k)
				4'd0: b = 8'h09; 4'd3: b = 8'h09; 4'd5: b = 8'h0f;
				default: b = 8'h00;
			endcase
		endcase
		return b;
	endfunction

	function automatic logic [7:0] ack_body(input logic [3:0] k, input logic [7:0] seq);
		logic [7:0] b;
		case (k)
			4'd0: b = 8'h01;
			4'd1: b = 8'h20;
			4'd2: b = seq;
			4'd3: b = 8'h09;
			4'd5: b = H0_GUIDE;
			4'd6: b = 8'h20;
			4'd7: b = 8'h02;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ src/gamepad_gip_host_sequencer.sv @@
// gamepad_gip_host_sequencer: host side of one wired gamepad link
// each event yields one verdict word, which follows any table slots walked and packet bytes
// emitted for it; input words are still taken while the back part works on earlier jobs
// input stalls only while the two-entry job queue is full; reset: control state and
// configuration registers clear, data registers do not
// depends on ggh_pkg, ggh_front, ggh_queue, ggh_back
module gamepad_gip_host_sequencer #(
	parameter int MAX_REPORT_BYTES = 64,
	parameter int INIT_TABLE_ENTRIES = 19
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input ggh_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output ggh_pkg::out_word_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	import ggh_pkg::*;

	logic gip_mode_q;
	logic [15:0] vid_q, pid_q;
	logic jv, full, qv, take;
	job_t jw, jr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gip_mode_q <= 1'b0;
			vid_q <= '0;
			pid_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GIP_MODE: gip_mode_q <= cfg_data[0];
				REG_VENDOR_ID: vid_q <= cfg_data;
				REG_PRODUCT_ID: pid_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ggh_front #(.MAX_REPORT_BYTES(MAX_REPORT_BYTES)) u_front (
		.clk, .arst_n, .gip_mode(gip_mode_q),
		.in_valid, .in_word(in_data), .in_stall,
		.job_valid(jv), .job(jw), .job_full(full)
	);

	ggh_queue u_queue (
		.clk, .arst_n, .wr_valid(jv), .wr_job(jw), .full,
		.rd_valid(qv), .rd_job(jr), .rd_take(take)
	);

	ggh_back #(.INIT_TABLE_ENTRIES(INIT_TABLE_ENTRIES)) u_back (
		.clk, .arst_n, .gip_mode(gip_mode_q), .dev_vid(vid_q), .dev_pid(pid_q),
		.job_valid(qv), .job(jr), .job_take(take),
		.out_valid, .out_word(out_data), .out_stall
	);
endmodule

@@ src/ggh_front.sv @@
// ggh_front: accepts input words, tracks the report stream and classifies events
// depends on ggh_pkg
module ggh_front #(
	parameter int MAX_REPORT_BYTES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic gip_mode,
	input logic in_valid,
	input ggh_pkg::in_word_t in_word,
	output logic in_stall,
	output logic job_valid,
	output ggh_pkg::job_t job,
	input logic job_full
);
	import ggh_pkg::*;

	localparam int PW = $clog2(MAX_REPORT_BYTES + 1);

	logic [PW-1:0] pos_q;
	logic [7:0] hdr_q [3];
	logic [7:0] key_off_q;
	logic key_state_q;
	logic key_cap_q;

	logic acc;
	logic [PW-1:0] len_c;
	logic [7:0] h0_c, h1_c, h2_c;
	logic [6:0] pairs;
	logic [7:0] off_c;
	logic store;
	logic hit;
	logic ks_c, kc_c;
	logic ev;

	assign in_stall = job_full;
	assign acc = in_valid && !job_full;
	assign store = (in_word.cmd == CMD_BYTE) && (pos_q < PW'(MAX_REPORT_BYTES));
	assign len_c = store ? pos_q + PW'(1) : pos_q;
	assign h0_c = (store && pos_q == PW'(0)) ? in_word.data_byte : hdr_q[0];
	assign h1_c = (store && pos_q == PW'(1)) ? in_word.data_byte : hdr_q[1];
	assign h2_c = (store && pos_q == PW'(2)) ? in_word.data_byte : hdr_q[2];
	assign pairs = in_word.data_byte[7:1];
	assign off_c = (pairs == 7'd0) ? 8'd0 : {pairs, 1'b0} + 8'd2;
	assign hit = store && pos_q >= PW'(4) && {{(8 > PW ? 8 - PW : 0){1'b0}}, pos_q} == key_off_q;
	assign ks_c = hit ? in_word.data_byte[0] : key_state_q;
	assign kc_c = hit ? 1'b1 : key_cap_q;
	assign ev = (in_word.cmd != CMD_BYTE) || in_word.final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			key_off_q <= '0;
			key_state_q <= 1'b0;
			key_cap_q <= 1'b0;
		end else if (acc) begin
			if (in_word.cmd == CMD_BYTE && !in_word.final_byte) begin
				pos_q <= len_c;
				key_state_q <= ks_c;
				key_cap_q <= kc_c;
				if (store && pos_q == PW'(3)) key_off_q <= off_c;
			end else if (in_word.cmd == CMD_BYTE) begin
				pos_q <= '0;
				key_state_q <= ks_c;
				key_cap_q <= 1'b0;
				if (store && pos_q == PW'(3)) key_off_q <= off_c;
			end else if (in_word.cmd != CMD_OUT_DONE) begin
				pos_q <= '0;
				key_cap_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && store && pos_q < PW'(3)) hdr_q[pos_q[1:0]] <= in_word.data_byte;
	end

	always_comb begin
		job = '{src: SRC_NONE, restart: 1'b0, player_number: in_word.player_number,
			ack_seq: h2_c, deliver_report: 1'b0, home_valid: 1'b0,
			home_pressed: 1'b0, rearm_in: 1'b0};
		case (in_word.cmd)
			CMD_START: begin
				job.rearm_in = 1'b1;
				if (gip_mode) begin
					job.src = SRC_WALK;
					job.restart = 1'b1;
				end else begin
					job.src = SRC_LED;
				end
			end
			CMD_OUT_DONE: begin
				if (in_word.xfer_status == ST_OK && gip_mode) job.src = SRC_WALK;
			end
			CMD_IN_FAIL: begin
				job.rearm_in = in_word.xfer_status != ST_STALL;
			end
			default: begin
				job.rearm_in = 1'b1;
				if (!gip_mode) begin
					job.deliver_report = h0_c == 8'h00 &&
						{{(8 > PW ? 8 - PW : 0){1'b0}}, len_c} >= MIN_LEGACY_LEN;
				end else if (h0_c == H0_ANNOUNCE && len_c >= PW'(4)) begin
					job.src = SRC_WALK;
					job.restart = 1'b1;
				end else if (h0_c == H0_GUIDE && len_c > PW'(4)) begin
					job.home_valid = kc_c;
					job.home_pressed = kc_c & ks_c;
					if (h1_c[4]) job.src = SRC_ACK;
				end else if (h0_c == H0_INPUT) begin
					job.deliver_report = 1'b1;
				end
			end
		endcase
	end

	assign job_valid = acc && ev;
endmodule

@@ src/ggh_queue.sv @@
// ggh_queue: two-entry job queue between the front and back parts
// depends on ggh_pkg
module ggh_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	input ggh_pkg::job_t wr_job,
	output logic full,
	output logic rd_valid,
	output ggh_pkg::job_t rd_job,
	input logic rd_take
);
	import ggh_pkg::*;

	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_valid) wp_q <= ~wp_q;
			if (rd_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_valid} - {1'b0, rd_take};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid) mem_q[wp_q] <= wr_job;
	end
endmodule

@@ src/ggh_back.sv @@
// ggh_back: runs jobs: init table walk, packet emission and verdict
// depends on ggh_pkg
module ggh_back #(
	parameter int INIT_TABLE_ENTRIES = 19
) (
	input logic clk,
	input logic arst_n,
	input logic gip_mode,
	input logic [15:0] dev_vid,
	input logic [15:0] dev_pid,
	input logic job_valid,
	input ggh_pkg::job_t job,
	output logic job_take,
	output logic out_valid,
	output ggh_pkg::out_word_t out_word,
	input logic out_stall
);
	import ggh_pkg::*;

	bk_state_t st_q, st_d;
	logic [4:0] idx_q;
	logic [7:0] seq_q;
	logic fin_q;
	logic [2:0] pkt_q;
	logic [3:0] k_q;
	logic [7:0] sseq_q;
	logic ack_q;

	init_entry_t e;
	logic match, past, last, live, found;
	logic [3:0] len;
	logic free;
	logic ov_q;
	out_word_t ow_q, ow_d;
	logic emit;

	assign e = init_entry(idx_q);
	assign past = {1'b0, idx_q} >= 6'(INIT_TABLE_ENTRIES);
	assign last = {1'b0, idx_q} == 6'(INIT_TABLE_ENTRIES - 1);
	assign live = {1'b0, idx_q} < 6'(DEFINED_SLOTS);
	assign match = (e.vid == 16'h0 || e.vid == dev_vid) &&
		(e.pid == 16'h0 || e.pid == dev_pid);
	assign found = live && match;
	assign len = ack_q ? 4'd13 : (job.src == SRC_LED) ? 4'd3 : pkt_len(pkt_q);
	assign free = !ov_q || !out_stall;
	assign out_valid = ov_q;
	assign out_word = ow_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: if (job_valid) begin
				if (job.src == SRC_LED || (job.src == SRC_ACK && fin_q)) st_d = BK_EMIT;
				else if (job.src == SRC_WALK && (job.restart || (gip_mode && !fin_q)))
					st_d = BK_WALK;
				else st_d = BK_VERDICT;
			end
			BK_WALK: if (past) st_d = BK_VERDICT;
				else if (found) st_d = BK_EMIT;
				else if (last) st_d = BK_VERDICT;
			BK_EMIT: if (free && k_q == len - 4'd1) st_d = BK_VERDICT;
			BK_VERDICT: if (free) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		job_take = 1'b0;
		ow_d = '0;
		case (st_q)
			BK_EMIT: begin
				emit = free;
				ow_d.kind = 1'b0;
				ow_d.packet_end = k_q == len - 4'd1;
				if (ack_q) ow_d.packet_byte = ack_body(k_q, sseq_q);
				else if (k_q == 4'd2 && !job.src[1]) ow_d.packet_byte = sseq_q;
				else if (job.src == SRC_LED) begin
					case (k_q)
						4'd0: ow_d.packet_byte = 8'h01;
						4'd1: ow_d.packet_byte = 8'h03;
						default: ow_d.packet_byte = 8'h06 + {6'd0, job.player_number};
					endcase
				end else ow_d.packet_byte = pkt_body(pkt_q, k_q);
			end
			BK_VERDICT: begin
				emit = free;
				job_take = free;
				ow_d.kind = 1'b1;
				ow_d.deliver_report = job.deliver_report;
				ow_d.home_valid = job.home_valid;
				ow_d.home_pressed = job.home_pressed;
				ow_d.rearm_in = job.rearm_in;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			idx_q <= '0;
			seq_q <= '0;
			fin_q <= 1'b0;
			k_q <= '0;
			ov_q <= 1'b0;
			ack_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			case (st_q)
				BK_IDLE: if (job_valid) begin
					k_q <= '0;
					ack_q <= job.src == SRC_ACK;
					if (job.restart) begin
						idx_q <= '0;
						seq_q <= '0;
						fin_q <= 1'b0;
					end
				end
				BK_WALK: begin
					if (past) fin_q <= 1'b1;
					else begin
						idx_q <= idx_q + 5'd1;
						if (found) seq_q <= seq_q + 8'd1;
						else if (last) fin_q <= 1'b1;
					end
				end
				BK_EMIT: if (free) k_q <= k_q + 4'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) ow_q <= ow_d;
		if (st_q == BK_IDLE && job_valid) begin
			sseq_q <= job.ack_seq;
			pkt_q <= 3'd0;
		end
		if (st_q == BK_WALK && !past && found) begin
			pkt_q <= e.pkt;
			sseq_q <= seq_q;
		end
	end
endmodule

@@ test/tb_gamepad_gip_host_sequencer.sv @@
// tb_gamepad_gip_host_sequencer: directed and random test of the gamepad host sequencer
// a scoreboard class predicts packet and verdict words; depends on ggh_pkg and the block
`timescale 1ns / 100ps

module tb_gamepad_gip_host_sequencer;
	import ggh_pkg::*;

	localparam int MAX_BYTES = 64;
	localparam int ENTRIES = 19;
	localparam int LIMIT = 2000000;

	class host_scoreboard;
		out_word_t pending[$];
		int errors;
		logic gip;
		logic [15:0] vid, pid;
		logic [4:0] idx;
		logic [7:0] seq;
		logic done;
		logic [6:0] pos;
		logic [7:0] hdr[4];
		logic [7:0] koff;
		logic kstate, kcap;

		function new();
			errors = 0;
			gip = 0; vid = 0; pid = 0;
			idx = 0; seq = 0; done = 0; pos = 0;
			koff = 0; kstate = 0; kcap = 0;
			foreach (hdr[i]) hdr[i] = 0;
		endfunction

		function void set_reg(logic [1:0] r, logic [15:0] v);
			if (r == REG_GIP_MODE) gip = v[0];
			else if (r == REG_VENDOR_ID) vid = v;
			else if (r == REG_PRODUCT_ID) pid = v;
		endfunction

		function void push_byte(logic [7:0] b, logic e);
			out_word_t w;
			w = '0;
			w.packet_byte = b;
			w.packet_end = e;
			pending.push_back(w);
		endfunction

		function void push_verdict(logic d, logic hv, logic hp, logic ra);
			out_word_t w;
			w = '0;
			w.kind = 1;
			w.deliver_report = d;
			w.home_valid = hv;
			w.home_pressed = hp;
			w.rearm_in = ra;
			pending.push_back(w);
		endfunction

		function void walk();
			int i;
			init_entry_t e;
			int n;
			i = int'(idx);
			while (i < ENTRIES) begin
				e = init_entry(i[4:0]);
				i++;
				if (e.vid != 0 && e.vid != vid) continue;
				if (e.pid != 0 && e.pid != pid) continue;
				n = int'(pkt_len(e.pkt));
				for (int k = 0; k < n; k++)
					push_byte(k == 2 ? seq : pkt_body(e.pkt, k[3:0]), k == n - 1);
				seq++;
				idx = i[4:0];
				return;
			end
			idx = i[4:0];
			done = 1;
		endfunction

		function void note_input(in_word_t w);
			int p, pairs, off;
			logic d, hv, hp;
			case (cmd_t'(w.cmd))
				CMD_START: begin
					pos = 0; kcap = 0;
					if (gip) begin
						idx = 0; seq = 0; done = 0;
						walk();
					end else begin
						push_byte(8'h01, 0);
						push_byte(8'h03, 0);
						push_byte(8'h06 + {6'd0, w.player_number}, 1);
					end
					push_verdict(0, 0, 0, 1);
				end
				CMD_OUT_DONE: begin
					if (w.xfer_status == ST_OK && gip && !done) walk();
					push_verdict(0, 0, 0, 0);
				end
				CMD_IN_FAIL: begin
					pos = 0; kcap = 0;
					push_verdict(0, 0, 0, w.xfer_status != ST_STALL);
				end
				default: begin
					if (pos < MAX_BYTES) begin
						p = int'(pos);
						if (p < 4) hdr[p] = w.data_byte;
						if (p == 3) begin
							pairs = int'(w.data_byte >> 1);
							off = pairs ? 4 + (pairs - 1) * 2 : 0;
							koff = off > 255 ? 8'd255 : off[7:0];
						end
						if (p >= 4 && p == int'(koff)) begin
							kstate = w.data_byte[0];
							kcap = 1;
						end
						pos = pos + 7'd1;
					end
					if (w.final_byte) begin
						d = 0; hv = 0; hp = 0;
						if (!gip) begin
							if (hdr[0] == 8'h00 && {1'b0, pos} >= MIN_LEGACY_LEN) d = 1;
						end else if (hdr[0] == H0_ANNOUNCE && pos >= 7'd4) begin
							idx = 0; seq = 0; done = 0;
							walk();
						end else if (hdr[0] == H0_GUIDE && pos > 7'd4) begin
							if (kcap) begin
								hv = 1; hp = kstate;
							end
							if (hdr[1][4] && done)
								for (int k = 0; k < 13; k++)
									push_byte(ack_body(k[3:0], hdr[2]), k == 12);
						end else if (hdr[0] == H0_INPUT) begin
							d = 1;
						end
						pos = 0; kcap = 0;
						push_verdict(d, hv, hp, 1);
					end
				end
			endcase
		endfunction

		function void check_output(out_word_t a);
			out_word_t x;
			if (pending.size() == 0) begin
				$error("unexpected word %h", a);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (a.kind !== x.kind) begin
				$error("kind exp %h got %h", x.kind, a.kind); errors++;
			end
			if (a.packet_byte !== x.packet_byte) begin
				$error("packet_byte exp %h got %h", x.packet_byte, a.packet_byte); errors++;
			end
			if (a.packet_end !== x.packet_end) begin
				$error("packet_end exp %h got %h", x.packet_end, a.packet_end); errors++;
			end
			if (a.deliver_report !== x.deliver_report) begin
				$error("deliver_report exp %h got %h", x.deliver_report, a.deliver_report);
				errors++;
			end
			if (a.home_valid !== x.home_valid) begin
				$error("home_valid exp %h got %h", x.home_valid, a.home_valid); errors++;
			end
			if (a.home_pressed !== x.home_pressed) begin
				$error("home_pressed exp %h got %h", x.home_pressed, a.home_pressed); errors++;
			end
			if (a.rearm_in !== x.rearm_in) begin
				$error("rearm_in exp %h got %h", x.rearm_in, a.rearm_in); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	in_word_t in_data;
	out_word_t out_data;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	host_scoreboard sb;
	int send_idle, recv_idle;
	int cycles;

	gamepad_gip_host_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 0;
	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver side: random stall, check each accepted word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_output(out_data);
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_gamepad_gip_host_sequencer failed");
			$finish;
		end
	end

	// valid stays up after the last word; drain and idles drop it
	task automatic send(in_word_t w);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(w);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] r, logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(r, v);
	endtask

	task automatic setup(logic g, logic [15:0] v, logic [15:0] p);
		drain();
		write_reg(REG_GIP_MODE, {15'd0, g});
		write_reg(REG_VENDOR_ID, v);
		write_reg(REG_PRODUCT_ID, p);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_word_t mk(cmd_t c, logic [7:0] d, logic f, logic [1:0] s,
			logic [1:0] pn);
		in_word_t w;
		w.cmd = c; w.data_byte = d; w.final_byte = f;
		w.xfer_status = s; w.player_number = pn;
		return w;
	endfunction

	task automatic report(int len, logic [7:0] h0, logic [7:0] h1, logic [7:0] h3);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == 0) b = h0;
			if (i == 1) b = h1;
			if (i == 3) b = h3;
			send(mk(CMD_BYTE, b, i == len - 1, 2'($urandom), 2'($urandom)));
		end
	endtask

	task automatic random_phase(int n);
		int r, done_items, len;
		logic [7:0] h0, h3;
		done_items = 0;
		while (done_items < n) begin
			r = $urandom_range(99);
			if (r < 15) begin
				send(mk(CMD_START, 8'($urandom), 1'($urandom), 2'($urandom), 2'($urandom)));
				done_items++;
			end else if (r < 45) begin
				send(mk(CMD_OUT_DONE, 8'($urandom), 1'($urandom),
					($urandom_range(3) != 0) ? ST_OK : 2'($urandom), 2'($urandom)));
				done_items++;
			end else if (r < 52) begin
				send(mk(CMD_IN_FAIL, 8'($urandom), 1'($urandom), 2'($urandom),
					2'($urandom)));
				done_items++;
			end else begin
				case ($urandom_range(5))
					0: h0 = H0_ANNOUNCE;
					1: h0 = H0_STATUS;
					2, 3: h0 = H0_GUIDE;
					4: h0 = H0_INPUT;
					default: h0 = $urandom_range(1) ? 8'h00 : 8'($urandom);
				endcase
				len = ($urandom_range(9) == 0) ? int'($urandom_range(60, 70)) :
					int'($urandom_range(1, 20));
				h3 = $urandom_range(1) ? 8'($urandom_range(0, 14)) : 8'($urandom);
				report(len, h0, 8'($urandom), h3);
				done_items += len;
			end
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		send_idle = 9;
		recv_idle = 88;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: legacy start and reports, then GIP mode starts, walks and reports
		send(mk(CMD_START, 8'h00, 0, ST_OK, 2'd0));
		send(mk(CMD_START, 8'hff, 1, 2'd3, 2'd3));
		report(14, 8'h00, 8'h00, 8'h00);
		report(13, 8'h00, 8'hff, 8'hff);
		send(mk(CMD_IN_FAIL, 8'h00, 0, ST_STALL, 2'd0));
		send(mk(CMD_IN_FAIL, 8'h00, 0, ST_OK, 2'd0));
		send(mk(CMD_OUT_DONE, 8'h00, 0, ST_OK, 2'd0));
		setup(1, 16'h24c6, 16'h541a);
		send(mk(CMD_START, 8'h00, 0, ST_OK, 2'd0));
		repeat (4) send(mk(CMD_OUT_DONE, 8'h00, 0, ST_OK, 2'd0));
		report(8, H0_GUIDE, 8'h10, 8'h04);
		report(5, H0_GUIDE, 8'h10, 8'hff);
		report(4, H0_ANNOUNCE, 8'h00, 8'h00);
		report(3, H0_STATUS, 8'h00, 8'h00);
		report(2, H0_INPUT, 8'h00, 8'h00);
		report(70, H0_INPUT, 8'h00, 8'h00);
		setup(1, 16'hffff, 16'hffff);
		send(mk(CMD_START, 8'h00, 0, ST_OK, 2'd0));
		send(mk(CMD_OUT_DONE, 8'h00, 0, 2'd2, 2'd0));
		send(mk(CMD_OUT_DONE, 8'h00, 0, ST_OK, 2'd0));

		// random phases across settings and idle mixes
		setup(1, 16'h0e6f, 16'h0000);
		random_phase(80);
		setup(0, 16'h0000, 16'h0000);
		random_phase(30);
		setup(1, 16'h1430, 16'h079b);
		send_idle = 88; recv_idle = 9;
		random_phase(80);
		drain();
		setup(1, 16'h045e, 16'h0b00);
		send_idle = 0; recv_idle = 0;
		random_phase(70);
		setup(1, 16'h24c6, 16'h543a);
		random_phase(40);

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_gamepad_gip_host_sequencer passed");
		else
			$display("tb_gamepad_gip_host_sequencer failed");
		$finish;
	end
endmodule

@@ filelist.f @@
src/ggh_pkg.sv
src/ggh_front.sv
src/ggh_queue.sv
src/ggh_back.sv
src/gamepad_gip_host_sequencer.sv
test/tb_gamepad_gip_host_sequencer.sv
